// ===== src/cbpg_pkg.sv =====
// Shared types, constants and color table for the color bar pattern generator.
package cbpg_pkg;

  localparam int unsigned DIM_W     = 13;
  localparam int unsigned COL_W     = 12;
  localparam int unsigned ROW_W     = 12;
  localparam int unsigned FRAME_W   = 24;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned BOX_SPAN  = 40;
  localparam int unsigned MAX_DIM   = 4096;
  localparam int unsigned BOX_LEVEL  = 255;
  localparam int unsigned BOX_CHROMA = 128;

  localparam int unsigned RESET_WIDTH  = 640;
  localparam int unsigned RESET_HEIGHT = 360;

  localparam int unsigned NUM_STAGES = 7;
  localparam int unsigned MOD_STEPS  = 4;
  localparam int unsigned BAR_STEPS  = 2;
  localparam int unsigned MOD_NUM_W  = NUM_STAGES * MOD_STEPS;
  localparam int unsigned BAR_NUM_W  = NUM_STAGES * BAR_STEPS;
  localparam int unsigned MOD_REM_W  = 12;
  localparam int unsigned BAR_DIV_W  = 10;
  localparam int unsigned BAR_IDX_W  = 3;

  localparam int unsigned FIFTH_MUL   = 13108;
  localparam int unsigned FIFTH_SHIFT = 16;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cbpg_reg_e;

  typedef struct packed {
    logic [COL_W-1:0]   pair_column;
    logic [ROW_W-1:0]   row_index;
    logic [FRAME_W-1:0] frame_index;
  } cbpg_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] luma_first;
    logic [BYTE_W-1:0] chroma_blue;
    logic [BYTE_W-1:0] luma_second;
    logic [BYTE_W-1:0] chroma_red;
  } cbpg_out_t;

  typedef struct packed {
    logic [DIM_W-1:0]     width;
    logic [DIM_W-1:0]     height;
    logic [DIM_W-1:0]     start_y;
    logic [BAR_DIV_W-1:0] bar_w;
    logic [MOD_REM_W-1:0] mod_div;
    logic                 box_en;
  } cbpg_geom_t;

  typedef struct packed {
    logic [MOD_NUM_W-1:0] mod_num;
    logic [MOD_REM_W-1:0] mod_rem;
    logic [BAR_NUM_W-1:0] bar_num;
    logic [BAR_DIV_W-1:0] bar_rem;
    logic [BAR_IDX_W-1:0] bar_quo;
    logic [COL_W-1:0]     col;
    logic [ROW_W-1:0]     row;
  } cbpg_pipe_t;

  function automatic cbpg_out_t bar_color(input logic [BAR_IDX_W-1:0] idx);
    cbpg_out_t c;
    case (idx)
      3'd0:    c = '{8'd235, 8'd128, 8'd235, 8'd128};
      3'd1:    c = '{8'd210, 8'd16,  8'd210, 8'd146};
      3'd2:    c = '{8'd170, 8'd166, 8'd170, 8'd16};
      3'd3:    c = '{8'd145, 8'd54,  8'd145, 8'd34};
      3'd4:    c = '{8'd106, 8'd202, 8'd106, 8'd222};
      3'd5:    c = '{8'd81,  8'd90,  8'd81,  8'd240};
      3'd6:    c = '{8'd41,  8'd240, 8'd41,  8'd110};
      default: c = '{8'd16,  8'd128, 8'd16,  8'd128};
    endcase
    return c;
  endfunction

endpackage

// ===== src/cbpg_cfg.sv =====
// Configuration registers and registered frame geometry derived from them.
module cbpg_cfg (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [cbpg_pkg::DIM_W-1:0] cfg_data_i,
  output cbpg_pkg::cbpg_geom_t     geom_o
);

  logic [cbpg_pkg::DIM_W-1:0] width_d, width_q, height_d, height_q;
  logic [cbpg_pkg::DIM_W-1:0] w_clamp, h_clamp, h_fifth;
  logic [cbpg_pkg::DIM_W+cbpg_pkg::FIFTH_SHIFT-1:0] h_prod;
  cbpg_pkg::cbpg_geom_t geom_d, geom_q;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i) begin
      case (cbpg_pkg::cbpg_reg_e'(cfg_idx_i))
        cbpg_pkg::REG_FRAME_WIDTH:  width_d  = cfg_data_i;
        cbpg_pkg::REG_FRAME_HEIGHT: height_d = cfg_data_i;
        default: ;
      endcase
    end
    w_clamp = (width_d > cbpg_pkg::DIM_W'(cbpg_pkg::MAX_DIM)) ?
              cbpg_pkg::DIM_W'(cbpg_pkg::MAX_DIM) : width_d;
    h_clamp = (height_d > cbpg_pkg::DIM_W'(cbpg_pkg::MAX_DIM)) ?
              cbpg_pkg::DIM_W'(cbpg_pkg::MAX_DIM) : height_d;
    h_prod  = (cbpg_pkg::DIM_W+cbpg_pkg::FIFTH_SHIFT)'(h_clamp) *
              (cbpg_pkg::DIM_W+cbpg_pkg::FIFTH_SHIFT)'(cbpg_pkg::FIFTH_MUL);
    h_fifth = h_prod[cbpg_pkg::FIFTH_SHIFT +: cbpg_pkg::DIM_W];
    geom_d.width   = w_clamp;
    geom_d.height  = h_clamp;
    geom_d.start_y = h_clamp - h_fifth;
    geom_d.bar_w   = (w_clamp[cbpg_pkg::DIM_W-1:3] == '0) ? cbpg_pkg::BAR_DIV_W'(1) :
                     w_clamp[3 +: cbpg_pkg::BAR_DIV_W];
    geom_d.box_en  = (w_clamp > cbpg_pkg::DIM_W'(cbpg_pkg::BOX_SPAN));
    geom_d.mod_div = cbpg_pkg::MOD_REM_W'(w_clamp - cbpg_pkg::DIM_W'(cbpg_pkg::BOX_SPAN));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= cbpg_pkg::DIM_W'(cbpg_pkg::RESET_WIDTH);
      height_q <= cbpg_pkg::DIM_W'(cbpg_pkg::RESET_HEIGHT);
      geom_q   <= '{
        width:   cbpg_pkg::DIM_W'(cbpg_pkg::RESET_WIDTH),
        height:  cbpg_pkg::DIM_W'(cbpg_pkg::RESET_HEIGHT),
        start_y: cbpg_pkg::DIM_W'(cbpg_pkg::RESET_HEIGHT - cbpg_pkg::RESET_HEIGHT / 5),
        bar_w:   cbpg_pkg::BAR_DIV_W'(cbpg_pkg::RESET_WIDTH / 8),
        mod_div: cbpg_pkg::MOD_REM_W'(cbpg_pkg::RESET_WIDTH - cbpg_pkg::BOX_SPAN),
        box_en:  1'b1
      };
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      geom_q   <= geom_d;
    end
  end

  assign geom_o = geom_q;

endmodule

// ===== src/cbpg_div_stage.sv =====
// One pipeline stage of the box offset remainder and bar index dividers.
module cbpg_div_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  cbpg_pkg::cbpg_pipe_t data_i,
  input  cbpg_pkg::cbpg_geom_t geom_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output cbpg_pkg::cbpg_pipe_t data_o
);

  logic                 valid_q;
  cbpg_pkg::cbpg_pipe_t data_d, data_q;
  logic [cbpg_pkg::MOD_REM_W:0] mod_t;
  logic [cbpg_pkg::BAR_DIV_W:0] bar_t;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    mod_t  = '0;
    bar_t  = '0;
    data_d = data_i;
    for (int i = 0; i < cbpg_pkg::MOD_STEPS; i++) begin
      mod_t = {data_d.mod_rem, data_d.mod_num[cbpg_pkg::MOD_NUM_W-1]};
      data_d.mod_num = data_d.mod_num << 1;
      if (mod_t >= {1'b0, geom_i.mod_div}) begin
        data_d.mod_rem = cbpg_pkg::MOD_REM_W'(mod_t - {1'b0, geom_i.mod_div});
      end else begin
        data_d.mod_rem = mod_t[cbpg_pkg::MOD_REM_W-1:0];
      end
    end
    for (int j = 0; j < cbpg_pkg::BAR_STEPS; j++) begin
      bar_t = {data_d.bar_rem, data_d.bar_num[cbpg_pkg::BAR_NUM_W-1]};
      data_d.bar_num = data_d.bar_num << 1;
      if (bar_t >= {1'b0, geom_i.bar_w}) begin
        data_d.bar_rem = cbpg_pkg::BAR_DIV_W'(bar_t - {1'b0, geom_i.bar_w});
        data_d.bar_quo = {data_d.bar_quo[cbpg_pkg::BAR_IDX_W-2:0], 1'b1};
      end else begin
        data_d.bar_rem = bar_t[cbpg_pkg::BAR_DIV_W-1:0];
        data_d.bar_quo = {data_d.bar_quo[cbpg_pkg::BAR_IDX_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== src/cbpg_out_stage.sv =====
// Box test, color selection and output register.
module cbpg_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  cbpg_pkg::cbpg_pipe_t data_i,
  input  cbpg_pkg::cbpg_geom_t geom_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output cbpg_pkg::cbpg_out_t  data_o
);

  logic                          valid_q;
  cbpg_pkg::cbpg_out_t           data_d, data_q;
  logic [cbpg_pkg::DIM_W-1:0]    box_x, box_end, col_ext, col_end, row_ext;
  logic                          in_cols, in_rows;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    box_x   = geom_i.box_en ? cbpg_pkg::DIM_W'(data_i.mod_rem) : '0;
    box_end = box_x + cbpg_pkg::DIM_W'(cbpg_pkg::BOX_SPAN);
    col_ext = cbpg_pkg::DIM_W'(data_i.col);
    col_end = col_ext + cbpg_pkg::DIM_W'(2);
    row_ext = cbpg_pkg::DIM_W'(data_i.row);
    in_cols = (col_ext >= box_x) && (col_ext < box_end) && (col_end <= geom_i.width);
    in_rows = (row_ext >= geom_i.start_y) && (row_ext < geom_i.height);
    if (in_cols && in_rows) begin
      data_d.luma_first  = cbpg_pkg::BYTE_W'(cbpg_pkg::BOX_LEVEL);
      data_d.chroma_blue = cbpg_pkg::BYTE_W'(cbpg_pkg::BOX_CHROMA);
      data_d.luma_second = cbpg_pkg::BYTE_W'(cbpg_pkg::BOX_LEVEL);
      data_d.chroma_red  = cbpg_pkg::BYTE_W'(cbpg_pkg::BOX_CHROMA);
    end else begin
      data_d = cbpg_pkg::bar_color(data_i.bar_quo);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== src/color_bar_pattern_generator.sv =====
// Top level of the YUYV color bar and moving box test pattern generator.
// Each input passes seven divider stages, each of four box remainder steps
// and two bar index steps, and then the output register.
// Throughput: one pixel pair per cycle; a stalled output holds the pipeline.
// Reset clears all valid bits and loads width 640 and height 360.
module color_bar_pattern_generator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [cbpg_pkg::DIM_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  cbpg_pkg::cbpg_in_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output cbpg_pkg::cbpg_out_t        out_data_o
);

  cbpg_pkg::cbpg_geom_t geom;
  cbpg_pkg::cbpg_pipe_t stage0_data;
  cbpg_pkg::cbpg_pipe_t pipe_data [cbpg_pkg::NUM_STAGES+1];
  logic [cbpg_pkg::NUM_STAGES:0] pipe_valid;
  logic [cbpg_pkg::NUM_STAGES:0] pipe_ready;

  cbpg_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .geom_o (geom)
  );

  always_comb begin
    stage0_data.mod_num = cbpg_pkg::MOD_NUM_W'({in_data_i.frame_index, 3'b000});
    stage0_data.mod_rem = '0;
    stage0_data.bar_num = cbpg_pkg::BAR_NUM_W'({in_data_i.pair_column[cbpg_pkg::COL_W-1:1],
                                               1'b0});
    stage0_data.bar_rem = '0;
    stage0_data.bar_quo = '0;
    stage0_data.col     = {in_data_i.pair_column[cbpg_pkg::COL_W-1:1], 1'b0};
    stage0_data.row     = in_data_i.row_index;
  end

  assign pipe_data[0]  = stage0_data;
  assign pipe_valid[0] = in_valid_i;
  assign in_ready_o    = pipe_ready[0];

  for (genvar s = 0; s < cbpg_pkg::NUM_STAGES; s++) begin : g_stage
    cbpg_div_stage u_stage (
      .clk_i,
      .rst_ni,
      .valid_i (pipe_valid[s]),
      .ready_o (pipe_ready[s]),
      .data_i  (pipe_data[s]),
      .geom_i  (geom),
      .valid_o (pipe_valid[s+1]),
      .ready_i (pipe_ready[s+1]),
      .data_o  (pipe_data[s+1])
    );
  end

  cbpg_out_stage u_out (
    .clk_i,
    .rst_ni,
    .valid_i (pipe_valid[cbpg_pkg::NUM_STAGES]),
    .ready_o (pipe_ready[cbpg_pkg::NUM_STAGES]),
    .data_i  (pipe_data[cbpg_pkg::NUM_STAGES]),
    .geom_i  (geom),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

endmodule

// ===== src/cbpg_checker.sv =====
// Port-level assertions for the color bar pattern generator, bound to the top level.
module cbpg_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input cbpg_pkg::cbpg_out_t        out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_stall_only_on_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  a_pair_luma_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.luma_first == out_data_o.luma_second)
    else $error("pair lumas differ");

  a_box_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.luma_first == 8'd255 |->
      out_data_o.chroma_blue == 8'd128 && out_data_o.chroma_red == 8'd128)
    else $error("box color malformed");

endmodule

bind color_bar_pattern_generator cbpg_checker u_cbpg_checker (.*);
